// ----- rtl/tbr_pkg.sv -----
package tbr_pkg;

  // default vertex coordinate width
  localparam int COORD_BITS_DEF = 10;

  // request type codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // multiplier issue slots per sequence, and the slot counter width
  localparam int SEQ_LEN  = 9;
  localparam int CNT_W    = 4;
  localparam logic [CNT_W-1:0] SEQ_LAST = CNT_W'(SEQ_LEN - 1);

  // multiplier operations; A starts a pair, B finishes it and stores the sum (the difference for den, nu and nv)
  typedef enum logic [4:0] {
    OP_NONE,
    OP_D00A, OP_D00B,
    OP_D01A, OP_D01B,
    OP_D11A, OP_D11B,
    OP_DENA, OP_DENB,
    OP_D02A, OP_D02B,
    OP_D12A, OP_D12B,
    OP_NUA,  OP_NUB,
    OP_NVA,  OP_NVB
  } mul_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PIX,
    ST_DRAIN,
    ST_DONE
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic    accept_load;
    logic    accept_step;
    mul_op_t op;
    logic    out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_active;
  } status_t;

  // per-triangle sequence: the edge dots d00, d01 and d11, then the denominator
  function automatic mul_op_t load_op(input logic [CNT_W-1:0] idx);
    mul_op_t op;
    case (idx)
      4'd0: op = OP_D00A;
      4'd1: op = OP_D00B;
      4'd2: op = OP_D01A;
      4'd3: op = OP_D01B;
      4'd4: op = OP_D11A;
      4'd5: op = OP_D11B;
      4'd6: op = OP_NONE;
      4'd7: op = OP_DENA;
      4'd8: op = OP_DENB;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  // per-pixel sequence: two point dots, then the two numerators
  function automatic mul_op_t pix_op(input logic [CNT_W-1:0] idx);
    mul_op_t op;
    case (idx)
      4'd0: op = OP_D02A;
      4'd1: op = OP_D02B;
      4'd2: op = OP_D12A;
      4'd3: op = OP_D12B;
      4'd4: op = OP_NONE;
      4'd5: op = OP_NUA;
      4'd6: op = OP_NUB;
      4'd7: op = OP_NVA;
      4'd8: op = OP_NVB;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

// ----- rtl/tbr_req_if.sv -----
interface tbr_req_if #(
  parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by_coord;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;

  modport source (output valid, req_type, ax, ay, bx, by_coord, cx, cy, input ready);
  modport sink   (input valid, req_type, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface

// ----- rtl/tbr_res_if.sv -----
interface tbr_res_if #(
  parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         inside_res;
  logic                         last;
  logic                         valid_pos;

  modport source (output valid, pixel_x, pixel_y, inside_res, last, valid_pos, input ready);
  modport sink   (input valid, pixel_x, pixel_y, inside_res, last, valid_pos, output ready);
endinterface

// ----- rtl/tbr_ctrl.sv -----
module tbr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_req_type,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  input  tbr_pkg::status_t status,
  output tbr_pkg::cmd_t    cmd
);

  tbr_pkg::ctl_state_t            state;
  tbr_pkg::ctl_state_t            state_next;
  logic [tbr_pkg::CNT_W-1:0]      cnt;
  logic [tbr_pkg::CNT_W-1:0]      cnt_next;
  logic                           out_valid_next;

  // state, slot counter and result-held flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tbr_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    cmd.accept_load = 1'b0;
    cmd.accept_step = 1'b0;
    cmd.op          = tbr_pkg::OP_NONE;
    cmd.out_load    = 1'b0;
    in_ready        = 1'b0;
    case (state)
      tbr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cnt_next = '0;
        if (in_valid) begin
          if (in_req_type == tbr_pkg::REQ_STEP) begin
            cmd.accept_step = 1'b1;
            state_next = status.scan_active ? tbr_pkg::ST_PIX : tbr_pkg::ST_DONE;
          end else begin
            cmd.accept_load = 1'b1;
            state_next = tbr_pkg::ST_LOAD;
          end
        end
      end
      tbr_pkg::ST_LOAD: begin
        cmd.op   = tbr_pkg::load_op(cnt);
        cnt_next = cnt + 1'b1;
        if (cnt == tbr_pkg::SEQ_LAST) state_next = tbr_pkg::ST_DRAIN;
      end
      tbr_pkg::ST_PIX: begin
        cmd.op   = tbr_pkg::pix_op(cnt);
        cnt_next = cnt + 1'b1;
        if (cnt == tbr_pkg::SEQ_LAST) state_next = tbr_pkg::ST_DRAIN;
      end
      tbr_pkg::ST_DRAIN: begin
        state_next = tbr_pkg::ST_DONE;
      end
      tbr_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = tbr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tbr_pkg::ST_IDLE;
      end
    endcase
  end

  // output register occupancy
  always_comb begin
    if (cmd.out_load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule

// ----- rtl/tbr_datapath.sv -----
module tbr_datapath #(
  parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tbr_pkg::cmd_t                cmd,
  output tbr_pkg::status_t             status,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by_coord,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic                         inside_res,
  output logic                         last,
  output logic                         valid_pos
);

  localparam int DIF_W  = COORD_BITS + 1;
  localparam int DOT_W  = 2 * COORD_BITS + 3;
  localparam int PROD_W = 2 * DOT_W;
  localparam int WIDE_W = PROD_W + 1;
  localparam int SUM_W  = WIDE_W + 1;

  // triangle state
  logic signed [COORD_BITS-1:0] ax_r, ay_r;
  logic signed [COORD_BITS-1:0] min_x, min_y, max_x, max_y;
  logic signed [COORD_BITS-1:0] box_min_x, box_min_y, box_max_x, box_max_y;
  logic signed [DIF_W-1:0]      e0x, e0y, e1x, e1y;
  logic signed [DOT_W-1:0]      d00, d01, d11;
  logic signed [WIDE_W-1:0]     den;

  // scan and per-pixel state
  logic                         scan_active;
  logic signed [COORD_BITS-1:0] scan_x, scan_y;
  logic                         end_px;
  logic signed [DIF_W-1:0]      wx, wy;
  logic signed [DOT_W-1:0]      d02, d12;
  logic signed [WIDE_W-1:0]     nu, nv;
  logic signed [COORD_BITS-1:0] res_x, res_y;
  logic                         res_last;
  logic                         res_pix;

  // shared multiplier
  logic signed [DOT_W-1:0]      mul_a, mul_b;
  logic signed [PROD_W-1:0]     prod;
  tbr_pkg::mul_op_t             op_q;
  logic signed [WIDE_W-1:0]     acc;
  logic signed [WIDE_W-1:0]     sum_add, sum_sub;

  // final test
  logic signed [SUM_W-1:0]      num_sum, margin;
  logic                         inside_calc;

  assign status.scan_active = scan_active;

  // bounding box of the incoming vertices
  always_comb begin
    min_x = (ax < bx) ? ax : bx;
    min_x = (min_x < cx) ? min_x : cx;
    max_x = (ax > bx) ? ax : bx;
    max_x = (max_x > cx) ? max_x : cx;
    min_y = (ay < by_coord) ? ay : by_coord;
    min_y = (min_y < cy) ? min_y : cy;
    max_y = (ay > by_coord) ? ay : by_coord;
    max_y = (max_y > cy) ? max_y : cy;
  end

  assign end_px = (scan_x == box_max_x) && (scan_y == box_max_y);

  // scan control flag
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
    end else if (cmd.accept_load) begin
      scan_active <= 1'b1;
    end else if (cmd.accept_step && scan_active && end_px) begin
      scan_active <= 1'b0;
    end
  end

  // triangle load and row-major scan
  always_ff @(posedge clk) begin
    if (cmd.accept_load) begin
      ax_r      <= ax;
      ay_r      <= ay;
      e0x       <= DIF_W'(cx) - DIF_W'(ax);
      e0y       <= DIF_W'(cy) - DIF_W'(ay);
      e1x       <= DIF_W'(bx) - DIF_W'(ax);
      e1y       <= DIF_W'(by_coord) - DIF_W'(ay);
      box_min_x <= min_x;
      box_min_y <= min_y;
      box_max_x <= max_x;
      box_max_y <= max_y;
      scan_x    <= min_x;
      scan_y    <= min_y;
      res_pix   <= 1'b0;
    end else if (cmd.accept_step) begin
      res_pix  <= scan_active;
      res_x    <= scan_x;
      res_y    <= scan_y;
      res_last <= end_px;
      wx       <= DIF_W'(scan_x) - DIF_W'(ax_r);
      wy       <= DIF_W'(scan_y) - DIF_W'(ay_r);
      if (scan_active && !end_px) begin
        if (scan_x >= box_max_x) begin
          scan_x <= box_min_x;
          scan_y <= scan_y + 1'b1;
        end else begin
          scan_x <= scan_x + 1'b1;
        end
      end
    end
  end

  // operand selection
  always_comb begin
    case (cmd.op)
      tbr_pkg::OP_D00A: begin mul_a = DOT_W'(e0x); mul_b = DOT_W'(e0x); end
      tbr_pkg::OP_D00B: begin mul_a = DOT_W'(e0y); mul_b = DOT_W'(e0y); end
      tbr_pkg::OP_D01A: begin mul_a = DOT_W'(e0x); mul_b = DOT_W'(e1x); end
      tbr_pkg::OP_D01B: begin mul_a = DOT_W'(e0y); mul_b = DOT_W'(e1y); end
      tbr_pkg::OP_D11A: begin mul_a = DOT_W'(e1x); mul_b = DOT_W'(e1x); end
      tbr_pkg::OP_D11B: begin mul_a = DOT_W'(e1y); mul_b = DOT_W'(e1y); end
      tbr_pkg::OP_DENA: begin mul_a = d00;         mul_b = d11;         end
      tbr_pkg::OP_DENB: begin mul_a = d01;         mul_b = d01;         end
      tbr_pkg::OP_D02A: begin mul_a = DOT_W'(e0x); mul_b = DOT_W'(wx);  end
      tbr_pkg::OP_D02B: begin mul_a = DOT_W'(e0y); mul_b = DOT_W'(wy);  end
      tbr_pkg::OP_D12A: begin mul_a = DOT_W'(e1x); mul_b = DOT_W'(wx);  end
      tbr_pkg::OP_D12B: begin mul_a = DOT_W'(e1y); mul_b = DOT_W'(wy);  end
      tbr_pkg::OP_NUA:  begin mul_a = d11;         mul_b = d02;         end
      tbr_pkg::OP_NUB:  begin mul_a = d01;         mul_b = d12;         end
      tbr_pkg::OP_NVA:  begin mul_a = d00;         mul_b = d12;         end
      tbr_pkg::OP_NVB:  begin mul_a = d01;         mul_b = d02;         end
      default:          begin mul_a = '0;          mul_b = '0;          end
    endcase
  end

  // product register and the op that produced it
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (rst) op_q <= tbr_pkg::OP_NONE;
    else     op_q <= cmd.op;
  end

  assign sum_add = acc + WIDE_W'(prod);
  assign sum_sub = acc - WIDE_W'(prod);

  // accumulate pairs and store results
  always_ff @(posedge clk) begin
    case (op_q)
      tbr_pkg::OP_D00A, tbr_pkg::OP_D01A, tbr_pkg::OP_D11A, tbr_pkg::OP_DENA,
      tbr_pkg::OP_D02A, tbr_pkg::OP_D12A, tbr_pkg::OP_NUA,  tbr_pkg::OP_NVA: begin
        acc <= WIDE_W'(prod);
      end
      tbr_pkg::OP_D00B: d00 <= DOT_W'(sum_add);
      tbr_pkg::OP_D01B: d01 <= DOT_W'(sum_add);
      tbr_pkg::OP_D11B: d11 <= DOT_W'(sum_add);
      tbr_pkg::OP_DENB: den <= sum_sub;
      tbr_pkg::OP_D02B: d02 <= DOT_W'(sum_add);
      tbr_pkg::OP_D12B: d12 <= DOT_W'(sum_add);
      tbr_pkg::OP_NUB:  nu  <= sum_sub;
      tbr_pkg::OP_NVB:  nv  <= sum_sub;
      default: begin
      end
    endcase
  end

  // inside when den != 0, nu >= 0, nv >= 0 and nu + nv <= den
  assign num_sum = SUM_W'(nu) + SUM_W'(nv);
  assign margin  = SUM_W'(den) - num_sum;
  assign inside_calc = (den != '0) && !nu[WIDE_W-1] && !nv[WIDE_W-1] && !margin[SUM_W-1];

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pixel_x    <= res_pix ? res_x : '0;
      pixel_y    <= res_pix ? res_y : '0;
      inside_res <= res_pix & inside_calc;
      last       <= res_pix & res_last;
      valid_pos  <= res_pix;
    end
  end

endmodule

// ----- rtl/triangle_bbox_rasterizer_unit.sv -----
// Triangle bounding-box rasterizer. A load request takes three signed
// vertices, stores their bounding box and edge dot products, and parks the
// scan on the box's top-left corner; each step request tests one pixel with
// exact integer barycentric arithmetic and advances the scan row-major.
// Every request gives one result. A load and a pixel step each pass through
// the issue slots of the single shared multiplier and a drain state before
// the result write state; a step while no scan is active goes straight to
// the result write state. That state waits while the output register holds
// a result not yet taken. One request is in work
// at a time; a new one is accepted while the previous result waits in the
// output register. Degenerate triangles scan their box with inside_res clear.
module triangle_bbox_rasterizer_unit #(
  parameter int COORD_BITS = tbr_pkg::COORD_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  tbr_req_if.sink  req_ch,
  tbr_res_if.source res_ch
);

  tbr_pkg::cmd_t    cmd;
  tbr_pkg::status_t status;

  // sequencing
  tbr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req_ch.valid),
    .in_req_type (req_ch.req_type),
    .in_ready    (req_ch.ready),
    .out_ready   (res_ch.ready),
    .out_valid   (res_ch.valid),
    .status      (status),
    .cmd         (cmd)
  );

  // arithmetic and scan state
  tbr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .ax         (req_ch.ax),
    .ay         (req_ch.ay),
    .bx         (req_ch.bx),
    .by_coord   (req_ch.by_coord),
    .cx         (req_ch.cx),
    .cy         (req_ch.cy),
    .pixel_x    (res_ch.pixel_x),
    .pixel_y    (res_ch.pixel_y),
    .inside_res (res_ch.inside_res),
    .last       (res_ch.last),
    .valid_pos  (res_ch.valid_pos)
  );

`ifndef SYNTHESIS
  // one request in work at a time
  assert property (@(posedge clk) disable iff (rst)
    (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
    else $error("request accepted while another is in work");

  // results without a pixel carry zero fields
  assert property (@(posedge clk) disable iff (rst)
    (res_ch.valid && !res_ch.valid_pos) |->
      (res_ch.pixel_x == '0 && res_ch.pixel_y == '0 && !res_ch.inside_res && !res_ch.last))
    else $error("non-pixel result has nonzero fields");

  // inside and last only on a scanned pixel
  assert property (@(posedge clk) disable iff (rst)
    (res_ch.valid && (res_ch.inside_res || res_ch.last)) |-> res_ch.valid_pos)
    else $error("inside or last flag without a scanned pixel");
`endif

endmodule

// ----- verif/triangle_bbox_rasterizer_unit_tb.sv -----
`timescale 1ns / 100ps

module triangle_bbox_rasterizer_unit_tb;

  localparam int CW = tbr_pkg::COORD_BITS_DEF;
  localparam int NUM_ITEMS = 1050;
  localparam int STUCK_LIMIT = 4000;
  localparam int PAUSE_EVERY = 250;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic          req_type;
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    logic [CW-1:0] bx;
    logic [CW-1:0] by_coord;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
  } req_t;

  typedef struct packed {
    logic [CW-1:0] pixel_x;
    logic [CW-1:0] pixel_y;
    logic          inside_res;
    logic          last;
    logic          valid_pos;
  } res_t;

  typedef struct packed {
    req_t rq;
    logic has_want;
    res_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  tbr_req_if req_ch ();
  tbr_res_if res_ch ();

  triangle_bbox_rasterizer_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .res_ch (res_ch)
  );

  // triangle state held by the predictor
  longint   tri_vtx [6];
  longint   tri_box [4];
  longint   tri_dots [3];
  longint   cur_x;
  longint   cur_y;
  bit       scanning;

  res_t     expected_pixels [$];
  dir_row_t dir_rows [$];
  int       err_count;
  int       sent_count;
  int       burst_left;
  int       stuck_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint lo3(longint a, longint b, longint c);
    longint m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic longint hi3(longint a, longint b, longint c);
    longint m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // exact barycentric coverage test against the stored triangle
  function automatic bit pixel_covered(longint px, longint py);
    longint e0x, e0y, e1x, e1y, wx, wy, d02, d12, den, nu, nv;
    e0x = tri_vtx[4] - tri_vtx[0];
    e0y = tri_vtx[5] - tri_vtx[1];
    e1x = tri_vtx[2] - tri_vtx[0];
    e1y = tri_vtx[3] - tri_vtx[1];
    wx  = px - tri_vtx[0];
    wy  = py - tri_vtx[1];
    d02 = e0x * wx + e0y * wy;
    d12 = e1x * wx + e1y * wy;
    den = tri_dots[0] * tri_dots[2] - tri_dots[1] * tri_dots[1];
    nu  = tri_dots[2] * d02 - tri_dots[1] * d12;
    nv  = tri_dots[0] * d12 - tri_dots[1] * d02;
    if (den == 0) return 1'b0;
    return (nu >= 0) && (nv >= 0) && (nu + nv <= den);
  endfunction

  // expected result of one request; updates the triangle state
  function automatic res_t rast_predict(req_t rq);
    res_t   r;
    longint e0x, e0y, e1x, e1y;
    bit     at_end;
    r = '0;
    if (rq.req_type == tbr_pkg::REQ_LOAD) begin
      tri_vtx[0] = longint'($signed(rq.ax));
      tri_vtx[1] = longint'($signed(rq.ay));
      tri_vtx[2] = longint'($signed(rq.bx));
      tri_vtx[3] = longint'($signed(rq.by_coord));
      tri_vtx[4] = longint'($signed(rq.cx));
      tri_vtx[5] = longint'($signed(rq.cy));
      tri_box[0] = lo3(tri_vtx[0], tri_vtx[2], tri_vtx[4]);
      tri_box[1] = lo3(tri_vtx[1], tri_vtx[3], tri_vtx[5]);
      tri_box[2] = hi3(tri_vtx[0], tri_vtx[2], tri_vtx[4]);
      tri_box[3] = hi3(tri_vtx[1], tri_vtx[3], tri_vtx[5]);
      e0x = tri_vtx[4] - tri_vtx[0];
      e0y = tri_vtx[5] - tri_vtx[1];
      e1x = tri_vtx[2] - tri_vtx[0];
      e1y = tri_vtx[3] - tri_vtx[1];
      tri_dots[0] = e0x * e0x + e0y * e0y;
      tri_dots[1] = e0x * e1x + e0y * e1y;
      tri_dots[2] = e1x * e1x + e1y * e1y;
      cur_x = tri_box[0];
      cur_y = tri_box[1];
      scanning = 1'b1;
    end else if (scanning) begin
      at_end = (cur_x == tri_box[2]) && (cur_y == tri_box[3]);
      r.pixel_x    = CW'(cur_x);
      r.pixel_y    = CW'(cur_y);
      r.inside_res = pixel_covered(cur_x, cur_y);
      r.last       = at_end;
      r.valid_pos  = 1'b1;
      // row-major advance
      if (at_end) begin
        scanning = 1'b0;
      end else if (cur_x >= tri_box[2]) begin
        cur_x = tri_box[0];
        cur_y = cur_y + 1;
      end else begin
        cur_x = cur_x + 1;
      end
    end
    return r;
  endfunction

  function automatic req_t mk_req(logic kind, int vax, int vay, int vbx, int vby,
                                  int vcx, int vcy);
    req_t r;
    r.req_type = kind;
    r.ax       = CW'(vax);
    r.ay       = CW'(vay);
    r.bx       = CW'(vbx);
    r.by_coord = CW'(vby);
    r.cx       = CW'(vcx);
    r.cy       = CW'(vcy);
    return r;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 1023)) - 512;
  endfunction

  function automatic req_t junk_step();
    return mk_req(tbr_pkg::REQ_STEP, rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord());
  endfunction

  function automatic void add_row(logic kind, int vax, int vay, int vbx, int vby,
                                  int vcx, int vcy, bit has_want, int px, int py,
                                  bit ins, bit lst, bit vp);
    dir_row_t d;
    d.rq              = mk_req(kind, vax, vay, vbx, vby, vcx, vcy);
    d.has_want        = has_want;
    d.want.pixel_x    = CW'(px);
    d.want.pixel_y    = CW'(py);
    d.want.inside_res = ins;
    d.want.last       = lst;
    d.want.valid_pos  = vp;
    dir_rows.push_back(d);
  endfunction

  function automatic void check_field(string name, logic [CW-1:0] want,
                                      logic [CW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
      err_count++;
    end
  endfunction

  // drive one request in bursts with random gaps; called at a falling edge
  task automatic send_request(req_t rq, bit has_want, res_t want);
    int   gap;
    res_t pred;
    if (burst_left == 0) begin
      if ($urandom_range(7) == 0) begin
        burst_left = $urandom_range(60, 150);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 12);
      end
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= rq.req_type;
    req_ch.ax       <= rq.ax;
    req_ch.ay       <= rq.ay;
    req_ch.bx       <= rq.bx;
    req_ch.by_coord <= rq.by_coord;
    req_ch.cx       <= rq.cx;
    req_ch.cy       <= rq.cy;
    do @(posedge clk); while (!req_ch.ready);
    pred = rast_predict(rq);
    expected_pixels.push_back(has_want ? want : pred);
    sent_count++;
    @(negedge clk);
  endtask

  // hold off the sender until every result is back
  task automatic wait_for_results();
    if (expected_pixels.size() != 0) begin
      req_ch.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clk);
    end
  endtask

  // result receiver with its own stall pattern
  initial begin
    int pct;
    int phase_cnt;
    pct = 0;
    phase_cnt = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (phase_cnt == 0) begin
        phase_cnt = $urandom_range(16, 96);
        case ($urandom_range(4))
          0, 1: pct = 0;
          2: pct = 30;
          3: pct = 60;
          default: pct = 90;
        endcase
      end
      phase_cnt--;
      res_ch.ready <= ($urandom_range(99) >= pct);
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result: pixel_x %0d pixel_y %0d", res_ch.pixel_x,
                 res_ch.pixel_y);
          err_count++;
        end else begin
          res_t want;
          want = expected_pixels.pop_front();
          check_field("pixel_x", want.pixel_x, res_ch.pixel_x);
          check_field("pixel_y", want.pixel_y, res_ch.pixel_y);
          check_field("inside_res", CW'(want.inside_res), CW'(res_ch.inside_res));
          check_field("last", CW'(want.last), CW'(res_ch.last));
          check_field("valid_pos", CW'(want.valid_pos), CW'(res_ch.valid_pos));
        end
      end
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // stimulus
  initial begin
    int   pick, span, base_x, base_y, area, n_steps;
    int   v [6];
    res_t none;
    none         = '0;
    err_count    = 0;
    sent_count   = 0;
    burst_left   = 0;
    stuck_cycles = 0;
    scanning     = 1'b0;
    cur_x        = 0;
    cur_y        = 0;
    foreach (tri_vtx[i]) tri_vtx[i] = 0;
    foreach (tri_box[i]) tri_box[i] = 0;
    foreach (tri_dots[i]) tri_dots[i] = 0;
    rst = 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= tbr_pkg::REQ_STEP;
    req_ch.ax       <= '0;
    req_ch.ay       <= '0;
    req_ch.bx       <= '0;
    req_ch.by_coord <= '0;
    req_ch.cx       <= '0;
    req_ch.cy       <= '0;

    // step while idle after reset
    add_row(tbr_pkg::REQ_STEP, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    // full-range triangle, then a reload in the middle of its scan
    add_row(tbr_pkg::REQ_LOAD, -512, -512, 511, -512, -512, 511, 1, 0, 0, 0, 0, 0);
    add_row(tbr_pkg::REQ_STEP, 0, 0, 0, 0, 0, 0, 1, -512, -512, 1, 0, 1);
    add_row(tbr_pkg::REQ_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // coincident vertices at the maximum corner: one pixel, never inside
    add_row(tbr_pkg::REQ_LOAD, 511, 511, 511, 511, 511, 511, 1, 0, 0, 0, 0, 0);
    add_row(tbr_pkg::REQ_STEP, 0, 0, 0, 0, 0, 0, 1, 511, 511, 0, 1, 1);
    add_row(tbr_pkg::REQ_STEP, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    // small triangle in the corner of the coordinate range, scanned to the end
    add_row(tbr_pkg::REQ_LOAD, 511, -512, 509, -512, 511, -510, 1, 0, 0, 0, 0, 0);
    repeat (9) add_row(tbr_pkg::REQ_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(tbr_pkg::REQ_STEP, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    // collinear vertices cover nothing
    add_row(tbr_pkg::REQ_LOAD, -3, 5, -2, 5, -1, 5, 1, 0, 0, 0, 0, 0);
    add_row(tbr_pkg::REQ_STEP, 0, 0, 0, 0, 0, 0, 1, -3, 5, 0, 0, 1);
    add_row(tbr_pkg::REQ_STEP, 0, 0, 0, 0, 0, 0, 1, -2, 5, 0, 0, 1);
    add_row(tbr_pkg::REQ_STEP, 0, 0, 0, 0, 0, 0, 1, -1, 5, 0, 1, 1);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) send_request(dir_rows[i].rq, dir_rows[i].has_want, dir_rows[i].want);
    wait_for_results();

    // random triangles, mostly small and fully scanned
    while (sent_count < NUM_ITEMS) begin
      if (sent_count % PAUSE_EVERY < 20 && $urandom_range(3) == 0) wait_for_results();
      pick = $urandom_range(99);
      if (pick < 80) begin
        span   = ($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 6);
        base_x = $urandom_range(0, 1023 - span) - 512;
        base_y = $urandom_range(0, 1023 - span) - 512;
        for (int k = 0; k < 6; k++) begin
          v[k] = ((k % 2) ? base_y : base_x) + $urandom_range(0, span);
        end
        if ($urandom_range(9) == 0) begin
          v[4] = v[0];
          v[5] = v[1];
        end
        send_request(mk_req(tbr_pkg::REQ_LOAD, v[0], v[1], v[2], v[3], v[4], v[5]),
                     0, none);
        area = int'((hi3(longint'(v[0]), longint'(v[2]), longint'(v[4])) -
                     lo3(longint'(v[0]), longint'(v[2]), longint'(v[4])) + 1) *
                    (hi3(longint'(v[1]), longint'(v[3]), longint'(v[5])) -
                     lo3(longint'(v[1]), longint'(v[3]), longint'(v[5])) + 1));
        if ($urandom_range(6) == 0) n_steps = $urandom_range(0, area - 1);
        else n_steps = area + $urandom_range(0, 2);
        repeat (n_steps) send_request(junk_step(), 0, none);
      end else if (pick < 92) begin
        // large triangle, abandoned after a few pixels
        send_request(mk_req(tbr_pkg::REQ_LOAD, rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord()), 0, none);
        repeat ($urandom_range(0, 6)) send_request(junk_step(), 0, none);
      end else begin
        send_request(junk_step(), 0, none);
      end
    end

    // drain and let any stray result show up
    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
